// File: hdl/view_cone_contact_scanner_assert.svh
// Assertion macros shared by the view cone contact scanner modules.
`ifndef VIEW_CONE_CONTACT_SCANNER_ASSERT_SVH
`define VIEW_CONE_CONTACT_SCANNER_ASSERT_SVH
`ifndef SYNTHESIS
// Check a consequence in the same cycle as its cause.
`define VCCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Check a consequence in the cycle after its cause.
`define VCCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VCCS_ASSERT_SAME(label, ante, cons, msg)
`define VCCS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: hdl/vccs_pkg.sv
// Types, constants and tables of the view cone contact scanner.
package vccs_pkg;

  // CORDIC sizing
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ITER_W = $clog2(CORDIC_ITERATIONS);
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W = 5;
  localparam int ATAN_W = 16;
  localparam int DIFF_W = 25;
  localparam int GUARD_W = 8;
  localparam int XY_W = 36;
  localparam int Z_W = 20;
  localparam int ANGLE_W = 16;
  localparam int REL_W = 18;

  // Gain correction multiply
  localparam int MAG_W = 34;
  localparam int MUL_HALF_W = 17;
  localparam int GAIN_W = 24;
  localparam int PROD_W = MUL_HALF_W + GAIN_W;
  localparam int ACC_W = 59;
  localparam int ACC_SHIFT = 32;
  localparam int DIST_W = 25;

  localparam int PI_Q13 = 25736;
  localparam int TWO_PI_Q13 = 51472;
  localparam int HALF_PI_Q16 = 102944;
  localparam logic [GAIN_W-1:0] INV_GAIN_Q24 = 24'd10188014;
  localparam logic [DIST_W-1:0] DIST_MAX = 25'd23726566;
  localparam logic [DIST_W-1:0] DIST_ONES = '1;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (ACC_SHIFT - 1));

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_RANGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_VIEW_ANGLE = 1'b1;

  typedef struct packed {
    logic [23:0] view_range;
    logic [14:0] half_view_angle;
  } cfg_t;

  typedef struct packed {
    logic [23:0]        observer_x;
    logic [23:0]        observer_y;
    logic signed [15:0] observer_heading;
    logic [15:0]        observer_size;
    logic [23:0]        target_x;
    logic [23:0]        target_y;
    logic [15:0]        target_size;
    logic [15:0]        target_id;
    logic               is_self;
    logic               first_of_scan;
    logic               last_of_scan;
  } pair_t;

  typedef struct packed {
    logic               visible;
    logic               in_contact;
    logic signed [15:0] relative_angle;
    logic [24:0]        distance;
    logic               nearest_valid;
    logic [15:0]        nearest_id;
    logic [24:0]        nearest_distance;
    logic               scan_done;
  } result_t;

  typedef struct packed {
    logic load;
    logic step;
  } cordic_ctl_t;

  typedef struct packed {
    logic last_iter;
  } cordic_sts_t;

  typedef struct packed {
    logic lo;
    logic hi;
    logic add;
  } scale_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_SCALE_LO,
    ST_SCALE_HI,
    ST_SCALE_ADD,
    ST_FINISH
  } state_t;

  // round(atan(2^-i) * 65536)
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      5'd0:    val = 16'd51472;
      5'd1:    val = 16'd30386;
      5'd2:    val = 16'd16055;
      5'd3:    val = 16'd8150;
      5'd4:    val = 16'd4091;
      5'd5:    val = 16'd2047;
      5'd6:    val = 16'd1024;
      5'd7:    val = 16'd512;
      5'd8:    val = 16'd256;
      5'd9:    val = 16'd128;
      5'd10:   val = 16'd64;
      5'd11:   val = 16'd32;
      5'd12:   val = 16'd16;
      5'd13:   val = 16'd8;
      5'd14:   val = 16'd4;
      5'd15:   val = 16'd2;
      5'd16:   val = 16'd1;
      default: val = 16'd0;
    endcase
    return val;
  endfunction

endpackage

// File: hdl/vccs_cfg.sv
// Configuration registers behind the APB-style port.
module vccs_cfg
  import vccs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2 +: CFG_IDX_W];
  assign wr_en   = psel && penable && pwrite && pready;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.view_range      <= '0;
      cfg.half_view_angle <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_VIEW_RANGE:      cfg.view_range      <= pwdata[23:0];
        REG_HALF_VIEW_ANGLE: cfg.half_view_angle <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_VIEW_RANGE:      prdata = PDATA_W'(cfg.view_range);
      REG_HALF_VIEW_ANGLE: prdata = PDATA_W'(cfg.half_view_angle);
      default:             prdata = '0;
    endcase
  end

endmodule

// File: hdl/vccs_cordic.sv
// Iterative vectoring CORDIC: one shift-add step per cycle while ctl.step is set.
`include "view_cone_contact_scanner_assert.svh"
module vccs_cordic
  import vccs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cordic_ctl_t               ctl,
  input  logic signed [DIFF_W-1:0]  dx,
  input  logic signed [DIFF_W-1:0]  dy,
  output cordic_sts_t               sts,
  output logic signed [ANGLE_W-1:0] bearing,
  output logic [MAG_W-1:0]          xmag
);

  localparam logic signed [Z_W-1:0] Z_HALF_PI = Z_W'(HALF_PI_Q16);
  localparam logic signed [Z_W-1:0] Z_PI = Z_W'(PI_Q13);
  localparam logic signed [Z_W-1:0] Z_NEG_PI = -Z_W'(PI_Q13);

  logic signed [XY_W-1:0] x, y, xs0, ys0, xsh, ysh;
  logic signed [Z_W-1:0]  z, z_step, z_sum, z_rnd, z_clamp;
  logic [ITER_W-1:0]      iter;
  logic                   zero_vec;

  // Scale the difference vector by the guard bits
  assign xs0 = {{(XY_W-DIFF_W-GUARD_W){dx[DIFF_W-1]}}, dx, {GUARD_W{1'b0}}};
  assign ys0 = {{(XY_W-DIFF_W-GUARD_W){dy[DIFF_W-1]}}, dy, {GUARD_W{1'b0}}};

  // Shared shifter and angle table
  assign xsh    = x >>> iter;
  assign ysh    = y >>> iter;
  assign z_step = {{(Z_W-ATAN_W){1'b0}}, atan_q16(ATAN_IDX_W'(iter))};

  // Load with pre-rotation into the right half plane, then rotate toward y = 0
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      zero_vec <= (dx == '0) && (dy == '0);
      if (dx[DIFF_W-1]) begin
        if (!dy[DIFF_W-1]) begin
          x <= ys0;
          y <= -xs0;
          z <= Z_HALF_PI;
        end else begin
          x <= -ys0;
          y <= xs0;
          z <= -Z_HALF_PI;
        end
      end else begin
        x <= xs0;
        y <= ys0;
        z <= '0;
      end
    end else if (ctl.step) begin
      if (!y[XY_W-1]) begin
        x <= x + ysh;
        y <= y - xsh;
        z <= z + z_step;
      end else begin
        x <= x - ysh;
        y <= y + xsh;
        z <= z - z_step;
      end
    end
  end

  // Count iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (ctl.load) begin
      iter <= '0;
    end else if (ctl.step) begin
      iter <= iter + ITER_W'(1);
    end
  end

  assign sts.last_iter = (iter == ITER_W'(CORDIC_ITERATIONS - 1));

  // Round the Q.16 angle to Q3.13 and clamp to plus or minus pi
  assign z_sum = z + Z_W'(4);
  assign z_rnd = z_sum >>> 3;
  always_comb begin
    if (z_rnd > Z_PI) begin
      z_clamp = Z_PI;
    end else if (z_rnd < Z_NEG_PI) begin
      z_clamp = Z_NEG_PI;
    end else begin
      z_clamp = z_rnd;
    end
  end
  assign bearing = zero_vec ? '0 : z_clamp[ANGLE_W-1:0];

  // Length before gain correction, negative read as zero
  assign xmag = x[XY_W-1] ? '0 : x[MAG_W-1:0];

  `VCCS_ASSERT_SAME(a_cordic_ctl_excl, ctl.step, !ctl.load, "cordic load and step together")
  `VCCS_ASSERT_SAME(a_cordic_right_half, ctl.step, !x[XY_W-1], "cordic x left right half plane")
  `VCCS_ASSERT_NEXT(a_cordic_stop, ctl.step && sts.last_iter, !ctl.step, "cordic stepped past end")

endmodule

// File: hdl/vccs_scale.sv
// Gain correction: length times inverse gain, in two half-width products.
module vccs_scale
  import vccs_pkg::*;
(
  input  logic              clk,
  input  scale_ctl_t        ctl,
  input  logic [MAG_W-1:0]  xmag,
  output logic [DIST_W-1:0] dist_val
);

  logic [MUL_HALF_W-1:0]       mul_a;
  logic [PROD_W-1:0]           product, prod;
  logic [ACC_W-1:0]            acc;
  logic [ACC_W-ACC_SHIFT-1:0]  quot;

  // Shared multiplier on one half of the length
  assign mul_a   = ctl.hi ? xmag[MAG_W-1:MUL_HALF_W] : xmag[MUL_HALF_W-1:0];
  assign product = PROD_W'(mul_a) * PROD_W'(INV_GAIN_Q24);

  // Register each product, then accumulate with the rounding half
  always_ff @(posedge clk) begin
    if (ctl.lo || ctl.hi) begin
      prod <= product;
    end
    if (ctl.hi) begin
      acc <= ACC_W'(prod) + ROUND_HALF;
    end else if (ctl.add) begin
      acc <= acc + (ACC_W'(prod) << MUL_HALF_W);
    end
  end

  // Drop the fraction and saturate
  assign quot = acc[ACC_W-1:ACC_SHIFT];
  assign dist_val = (quot > (ACC_W-ACC_SHIFT)'(DIST_MAX)) ? DIST_MAX : quot[DIST_W-1:0];

endmodule

// File: hdl/view_cone_contact_scanner.sv
// Top level: sequencer, sector and contact tests, nearest contact, result register.
//
//   channel  | signals                                    | carries
//   ---------+--------------------------------------------+----------------------------
//   pair     | pair_valid, pair_stall, pair               | observer/target pair in
//   result   | result_valid, result_stall, result         | flags, angle, distance out
//   config   | psel, penable, pwrite, paddr, pwdata, ...  | view_range, half_view_angle
//
// From accept to result register an item runs the CORDIC loop on the shared shift-add
// unit (ST_ROTATE), then ST_SCALE_LO, ST_SCALE_HI and ST_SCALE_ADD on the shared
// gain-correction multiplier, and last the evaluate state ST_FINISH.
// A new item can be taken as soon as the previous result shows in the result register.
// A stalled result holds in its register while the next item computes; that item
// then waits in its last cycle until the register frees.
// Reset is synchronous, clears control, config, result_valid and the nearest contact; no sweep.
`include "view_cone_contact_scanner_assert.svh"
module view_cone_contact_scanner
  import vccs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               pair_valid,
  output logic               pair_stall,
  input  pair_t              pair,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam logic signed [REL_W-1:0] REL_PI = REL_W'(PI_Q13);
  localparam logic signed [REL_W-1:0] REL_NEG_PI = -REL_W'(PI_Q13);
  localparam logic signed [REL_W-1:0] REL_TWO_PI = REL_W'(TWO_PI_Q13);

  state_t      state, state_next;
  cfg_t        cfg;
  cordic_ctl_t cordic_ctl;
  cordic_sts_t cordic_sts;
  scale_ctl_t  scale_ctl;
  pair_t       item;
  logic        out_free, finish_load;

  logic signed [DIFF_W-1:0]  dx, dy;
  logic signed [ANGLE_W-1:0] bearing;
  logic [MAG_W-1:0]          xmag;
  logic [DIST_W-1:0]         dist_val;

  logic              best_valid, cur_valid, new_valid;
  logic [15:0]       best_id, cur_id, new_id;
  logic [DIST_W-1:0] best_distance, cur_distance, new_distance;

  logic signed [REL_W-1:0] head_ext, bear_ext, rel_raw, rel_wrap, rel_neg;
  logic [ANGLE_W-1:0]      rel_mag;
  logic [16:0]             size_sum;
  logic                    in_range, vis, con, take;
  result_t                 res_next;

  vccs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Difference vector straight from the incoming item
  assign dx = $signed({1'b0, pair.target_x}) - $signed({1'b0, pair.observer_x});
  assign dy = $signed({1'b0, pair.target_y}) - $signed({1'b0, pair.observer_y});

  vccs_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .ctl     (cordic_ctl),
    .dx      (dx),
    .dy      (dy),
    .sts     (cordic_sts),
    .bearing (bearing),
    .xmag    (xmag)
  );

  vccs_scale u_scale (
    .clk      (clk),
    .ctl      (scale_ctl),
    .xmag     (xmag),
    .dist_val (dist_val)
  );

  assign out_free = !result_valid || !result_stall;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (pair_valid) state_next = ST_ROTATE;
      ST_ROTATE:    if (cordic_sts.last_iter) state_next = ST_SCALE_LO;
      ST_SCALE_LO:  state_next = ST_SCALE_HI;
      ST_SCALE_HI:  state_next = ST_SCALE_ADD;
      ST_SCALE_ADD: state_next = ST_FINISH;
      ST_FINISH:    if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pair_stall      = 1'b1;
    cordic_ctl      = '0;
    scale_ctl       = '0;
    finish_load     = 1'b0;
    case (state)
      ST_IDLE: begin
        pair_stall      = 1'b0;
        cordic_ctl.load = pair_valid;
      end
      ST_ROTATE:    cordic_ctl.step = 1'b1;
      ST_SCALE_LO:  scale_ctl.lo = 1'b1;
      ST_SCALE_HI:  scale_ctl.hi = 1'b1;
      ST_SCALE_ADD: scale_ctl.add = 1'b1;
      ST_FINISH:    finish_load = out_free;
      default: ;
    endcase
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cordic_ctl.load) begin
      item <= pair;
    end
  end

  // Relative angle, wrapped once into plus or minus pi
  assign head_ext = {{(REL_W-ANGLE_W){item.observer_heading[ANGLE_W-1]}}, item.observer_heading};
  assign bear_ext = {{(REL_W-ANGLE_W){bearing[ANGLE_W-1]}}, bearing};
  assign rel_raw  = head_ext - bear_ext;
  always_comb begin
    if (rel_raw > REL_PI) begin
      rel_wrap = rel_raw - REL_TWO_PI;
    end else if (rel_raw < REL_NEG_PI) begin
      rel_wrap = rel_raw + REL_TWO_PI;
    end else begin
      rel_wrap = rel_raw;
    end
  end
  assign rel_neg = -rel_wrap;
  assign rel_mag = rel_wrap[REL_W-1] ? rel_neg[ANGLE_W-1:0] : rel_wrap[ANGLE_W-1:0];

  // Range, cone and contact tests
  assign size_sum = {1'b0, item.observer_size} + {1'b0, item.target_size};
  assign in_range = dist_val <= {1'b0, cfg.view_range};
  assign vis = !item.is_self && in_range && (rel_mag <= {1'b0, cfg.half_view_angle});
  assign con = !item.is_self && in_range && (dist_val <= DIST_W'(size_sum));

  // Nearest contact, cleared at the start of a scan
  assign cur_valid    = item.first_of_scan ? 1'b0 : best_valid;
  assign cur_id       = item.first_of_scan ? '0 : best_id;
  assign cur_distance = item.first_of_scan ? DIST_ONES : best_distance;
  assign take         = con && (!cur_valid || (dist_val < cur_distance));
  assign new_valid    = take ? 1'b1 : cur_valid;
  assign new_id       = take ? item.target_id : cur_id;
  assign new_distance = take ? dist_val : cur_distance;

  always_comb begin
    res_next.visible          = vis;
    res_next.in_contact       = con;
    res_next.relative_angle   = item.is_self ? '0 : rel_wrap[ANGLE_W-1:0];
    res_next.distance         = item.is_self ? '0 : dist_val;
    res_next.nearest_valid    = new_valid;
    res_next.nearest_id       = new_valid ? new_id : '0;
    res_next.nearest_distance = new_valid ? new_distance : '0;
    res_next.scan_done        = item.last_of_scan;
  end

  // Update the nearest contact as the item completes
  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid    <= 1'b0;
      best_id       <= '0;
      best_distance <= DIST_ONES;
    end else if (finish_load) begin
      best_valid    <= new_valid;
      best_id       <= new_id;
      best_distance <= new_distance;
    end
  end

  // Result register: load on completion, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish_load) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_load) begin
      result <= res_next;
    end
  end

  `VCCS_ASSERT_NEXT(a_accept_starts, pair_valid && !pair_stall, state == ST_ROTATE, "item not started")
  `VCCS_ASSERT_SAME(a_nearest_clear, result_valid && !result.nearest_valid, (result.nearest_id == '0) && (result.nearest_distance == '0), "stale nearest contact")
  `VCCS_ASSERT_SAME(a_flags_in_range, result_valid && (result.visible || result.in_contact), result.distance <= {1'b0, cfg.view_range}, "flag set out of range")
  `VCCS_ASSERT_SAME(a_contact_nearest, result_valid && result.in_contact, result.nearest_valid && (result.nearest_distance <= result.distance), "contact not tracked")

endmodule
